// ===== rtl/core/nearest_track_association_defines.svh =====
// Assertion macros
`ifndef NEAREST_TRACK_ASSOCIATION_DEFINES_SVH
`define NEAREST_TRACK_ASSOCIATION_DEFINES_SVH
`ifndef SYNTHESIS
`define NTA_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define NTA_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define NTA_ASSERT_IMP(label, clk, rst_n, a, c)
`define NTA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/core/nta_pkg.sv =====
package nta_pkg;
    localparam int CMD_BITS    = 1;
    localparam int AREA_BITS   = 23;
    localparam int RAD_BITS    = 11;
    localparam int LANE_BITS   = 4;
    localparam int STATUS_BITS = 3;
    localparam int IDX_BITS    = 6;
    localparam int COL_BITS    = 2;
    localparam int OUT_C_BITS  = 11;
    localparam int CHG_BITS    = 16;
    localparam int LIVE_BITS   = 7;
    localparam int CFG_ADDR_BITS = 1;

    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_AREA = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RADIUS   = 1'd1;

    localparam logic [STATUS_BITS-1:0] ST_MATCH = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NEW   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_SMALL = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FRAME = 3'd4;

    localparam logic [COL_BITS-1:0] COL_BLUE  = 2'd0;
    localparam logic [COL_BITS-1:0] COL_GREEN = 2'd1;
    localparam logic [COL_BITS-1:0] COL_RED   = 2'd2;

    localparam logic [CMD_BITS-1:0] CMD_DET   = 1'b0;
    localparam logic [CMD_BITS-1:0] CMD_FRAME = 1'b1;

    localparam logic [AREA_BITS-1:0] MIN_AREA_RST = 23'd800;
    localparam logic [RAD_BITS-1:0]  RADIUS_RST   = 11'd20;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [IDX_BITS-1:0]    track_index;
        logic                   lane_changed;
        logic [COL_BITS-1:0]    color;
        logic [OUT_C_BITS-1:0]  out_x;
        logic [OUT_C_BITS-1:0]  out_y;
        logic [OUT_C_BITS-1:0]  out_width;
        logic [OUT_C_BITS-1:0]  out_height;
        logic [CHG_BITS-1:0]    changes_total;
        logic [LIVE_BITS-1:0]   tracks_live;
    } result_t;
endpackage

// ===== rtl/core/nta_if.sv =====
interface nta_det_if #(parameter int CB = 11);
    import nta_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   cmd;
    logic [CB-1:0]         box_x;
    logic [CB-1:0]         box_y;
    logic [CB-1:0]         box_width;
    logic [CB-1:0]         box_height;
    logic [AREA_BITS-1:0]  area;
    logic [LANE_BITS-1:0]  lane;
    modport source (output valid, cmd, box_x, box_y, box_width, box_height, area, lane,
                    input ready);
    modport sink (input valid, cmd, box_x, box_y, box_width, box_height, area, lane,
                  output ready);
endinterface

interface nta_res_if;
    import nta_pkg::*;
    logic    valid;
    logic    ready;
    result_t res;
    modport source (output valid, res, input ready);
    modport sink (input valid, res, output ready);
endinterface

// ===== rtl/core/nta_dist.sv =====
module nta_dist #(
    parameter int CB = 11
) (
    input  logic            clk,
    input  logic [CB-1:0]   tx,
    input  logic [CB-1:0]   ty,
    input  logic [CB-1:0]   tw,
    input  logic [CB-1:0]   th,
    input  logic [CB:0]     cx,
    input  logic [CB:0]     cy,
    output logic [2*CB+2:0] sq_dist
);
    logic [CB:0]     tcx, tcy;
    logic [CB+1:0]   sx, sy;
    logic [CB:0]     dx_reg, dy_reg;
    logic [2*CB+1:0] qx_reg, qy_reg;

    assign sx  = ({2'b0, tx} << 1) + {2'b0, tw};
    assign sy  = ({2'b0, ty} << 1) + {2'b0, th};
    assign tcx = sx[CB+1:1];
    assign tcy = sy[CB+1:1];

    always_ff @(posedge clk)
    begin
        dx_reg <= (tcx > cx) ? tcx - cx : cx - tcx;
        dy_reg <= (tcy > cy) ? tcy - cy : cy - tcy;
        qx_reg <= dx_reg * dx_reg;
        qy_reg <= dy_reg * dy_reg;
    end

    assign sq_dist = {1'b0, qx_reg} + {1'b0, qy_reg};
endmodule

// ===== rtl/core/nearest_track_association.sv =====
// Result timing from accept: a too-small item is answered from a register loaded at accept;
// new track or table full after the scan and the drain of the distance pipeline; a match
// after scan, drain, read and write-back; end of frame after the compaction pass.
// Throughput: one item at a time, the scan reading one track per cycle; the next item is
// taken only after its result is accepted. Reset clears live count, change counter, seen
// bits, state and counters and loads the config defaults; the track memory is not cleared.
module nearest_track_association #(
    parameter int MAX_TRACKS = 64,
    parameter int COORD_BITS = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    nta_det_if.sink                     det,
    nta_res_if.source                   res,
    input  logic                        cfg_we,
    input  logic [nta_pkg::CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [nta_pkg::AREA_BITS-1:0]     cfg_data
);
    import nta_pkg::*;
    `include "nearest_track_association_defines.svh"

    localparam int AW = $clog2(MAX_TRACKS);
    localparam int CW = $clog2(MAX_TRACKS + 1);
    localparam int CB = COORD_BITS;
    localparam int EW = 4 * CB + LANE_BITS + COL_BITS;
    localparam int DW = 2 * CB + 3;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;
    localparam logic [2:0] S_COMP  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [EW-1:0] mem [MAX_TRACKS];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    logic [2:0]            state_reg;
    logic [AREA_BITS-1:0]  min_area_reg;
    logic [RAD_BITS-1:0]   radius_reg;
    logic [CW-1:0]         live_reg;
    logic [CHG_BITS-1:0]   chg_reg;
    logic [MAX_TRACKS-1:0] seen_reg;
    logic [CW-1:0]         rd_cnt_reg;
    logic [CW-1:0]         wr_cnt_reg;
    logic [AW-1:0]         best_reg;
    logic [DW-1:0]         bestd_reg;
    logic                  found_reg;
    logic                  vld1_reg, vld2_reg, vld3_reg;
    logic [AW-1:0]         idx1_reg, idx2_reg, idx3_reg;
    logic [CB-1:0]         bx_reg, by_reg, bw_reg, bh_reg;
    logic [CB:0]           cx_reg, cy_reg;
    logic [LANE_BITS-1:0]  lane_reg;
    logic                  out_valid_reg;
    result_t               out_reg;
    result_t               res_val;
    logic [2*RAD_BITS-1:0] lim_reg;

    logic [CB-1:0] ex, ey, ew, eh;
    logic [LANE_BITS-1:0] elane;
    logic [COL_BITS-1:0]  ecol;
    logic [DW-1:0] sq_dist;
    logic [CB+1:0] scx, scy;

    assign {ex, ey, ew, eh, elane, ecol} = rd_data_reg;
    assign scx = ({2'b0, det.box_x} << 1) + {2'b0, det.box_width};
    assign scy = ({2'b0, det.box_y} << 1) + {2'b0, det.box_height};

    nta_dist #(.CB(CB)) u_dist (
        .clk (clk), .tx (ex), .ty (ey), .tw (ew), .th (eh),
        .cx (cx_reg), .cy (cy_reg), .sq_dist (sq_dist)
    );

    assign det.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign res.valid = out_valid_reg;
    assign res.res   = out_reg;

    logic accept;
    assign accept = det.valid && det.ready;

    logic [CB-1:0] nw, nh;
    logic          lchg;
    assign nw   = (bw_reg < ew) ? bw_reg : ew;
    assign nh   = (bh_reg < eh) ? bh_reg : eh;
    assign lchg = (elane != lane_reg);

    logic [COL_BITS-1:0] ncol;
    always_comb
    begin
        case (lane_reg)
            4'd1:    ncol = COL_BLUE;
            4'd2:    ncol = COL_GREEN;
            default: ncol = COL_RED;
        endcase
    end

    always_comb
    begin
        res_val               = '0;
        res_val.changes_total = chg_reg;
        res_val.tracks_live   = LIVE_BITS'(live_reg);
        case (state_reg)
            S_IDLE:
            begin
                res_val.status = ST_SMALL;
            end
            S_DRAIN:
            begin
                if (live_reg == CW'(MAX_TRACKS))
                begin
                    res_val.status = ST_FULL;
                end
                else
                begin
                    res_val.status       = ST_NEW;
                    res_val.track_index  = IDX_BITS'(live_reg);
                    res_val.color        = ncol;
                    res_val.lane_changed = (ncol == COL_RED);
                    res_val.out_x        = OUT_C_BITS'(bx_reg);
                    res_val.out_y        = OUT_C_BITS'(by_reg);
                    res_val.out_width    = OUT_C_BITS'(bw_reg);
                    res_val.out_height   = OUT_C_BITS'(bh_reg);
                    res_val.tracks_live  = LIVE_BITS'(live_reg + 1'b1);
                    if (ncol == COL_RED)
                    begin
                        res_val.changes_total = chg_reg + 1'b1;
                    end
                end
            end
            S_WB:
            begin
                res_val.status       = ST_MATCH;
                res_val.track_index  = IDX_BITS'(best_reg);
                res_val.lane_changed = lchg;
                res_val.color        = lchg ? COL_RED : ecol;
                res_val.out_x        = OUT_C_BITS'(bx_reg);
                res_val.out_y        = OUT_C_BITS'(by_reg);
                res_val.out_width    = OUT_C_BITS'(nw);
                res_val.out_height   = OUT_C_BITS'(nh);
                if (lchg)
                begin
                    res_val.changes_total = chg_reg + 1'b1;
                end
            end
            S_COMP:
            begin
                res_val.status      = ST_FRAME;
                res_val.tracks_live = LIVE_BITS'(wr_cnt_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        rd_addr = rd_cnt_reg[AW-1:0];
        if (state_reg == S_RD || state_reg == S_WB)
        begin
            rd_addr = best_reg;
        end
        wr_en   = 1'b0;
        wr_addr = best_reg;
        wr_data = {bx_reg, by_reg, nw, nh, lane_reg, lchg ? COL_RED : ecol};
        if (state_reg == S_WB)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_COMP && vld1_reg)
        begin
            wr_en   = seen_reg[idx1_reg];
            wr_addr = wr_cnt_reg[AW-1:0];
            wr_data = rd_data_reg;
        end
        else if (state_reg == S_DRAIN && !found_reg && live_reg != CW'(MAX_TRACKS)
                 && !vld1_reg && !vld2_reg && !vld3_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = live_reg[AW-1:0];
            wr_data = {bx_reg, by_reg, bw_reg, bh_reg, lane_reg, ncol};
        end
    end

    logic [DW-1:0] lim_ext;
    assign lim_ext = DW'(lim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_area_reg  <= MIN_AREA_RST;
            radius_reg    <= RADIUS_RST;
            live_reg      <= '0;
            chg_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            vld3_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_AREA: min_area_reg <= cfg_data;
                    REG_RADIUS:   radius_reg   <= cfg_data[RAD_BITS-1:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            vld1_reg <= 1'b0;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            idx1_reg <= rd_cnt_reg[AW-1:0];
            idx2_reg <= idx1_reg;
            idx3_reg <= idx2_reg;
            lim_reg  <= radius_reg * radius_reg;

            unique case (state_reg)
                S_IDLE:
                begin
                    rd_cnt_reg <= '0;
                    wr_cnt_reg <= '0;
                    found_reg  <= 1'b0;
                    if (accept)
                    begin
                        bx_reg   <= det.box_x;
                        by_reg   <= det.box_y;
                        bw_reg   <= det.box_width;
                        bh_reg   <= det.box_height;
                        cx_reg   <= scx[CB+1:1];
                        cy_reg   <= scy[CB+1:1];
                        lane_reg <= det.lane;
                        if (det.cmd == CMD_FRAME)
                        begin
                            state_reg <= S_COMP;
                        end
                        else if (det.area < min_area_reg)
                        begin
                            out_reg       <= res_val;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (rd_cnt_reg < live_reg)
                    begin
                        vld1_reg   <= 1'b1;
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!vld1_reg && !vld2_reg && !vld3_reg)
                    begin
                        if (found_reg)
                        begin
                            state_reg <= S_RD;
                        end
                        else if (live_reg == CW'(MAX_TRACKS))
                        begin
                            out_reg       <= res_val;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            out_reg <= res_val;
                            if (ncol == COL_RED)
                            begin
                                chg_reg <= chg_reg + 1'b1;
                            end
                            seen_reg[live_reg[AW-1:0]] <= 1'b1;
                            live_reg      <= live_reg + 1'b1;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    out_reg <= res_val;
                    if (lchg)
                    begin
                        chg_reg <= chg_reg + 1'b1;
                    end
                    seen_reg[best_reg] <= 1'b1;
                    out_valid_reg      <= 1'b1;
                    state_reg          <= S_IDLE;
                end
                S_COMP:
                begin
                    if (rd_cnt_reg < live_reg)
                    begin
                        vld1_reg   <= 1'b1;
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    if (vld1_reg && seen_reg[idx1_reg])
                    begin
                        wr_cnt_reg <= wr_cnt_reg + 1'b1;
                    end
                    if (!(rd_cnt_reg < live_reg) && !vld1_reg)
                    begin
                        live_reg      <= wr_cnt_reg;
                        seen_reg      <= '0;
                        out_reg       <= res_val;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if ((state_reg == S_SCAN || state_reg == S_DRAIN) && vld3_reg
                && sq_dist <= lim_ext && (!found_reg || sq_dist < bestd_reg))
            begin
                found_reg <= 1'b1;
                bestd_reg <= sq_dist;
                best_reg  <= idx3_reg;
            end
        end
    end

    `NTA_ASSERT_IMP(a_ready_idle, clk, rst_n, det.ready, state_reg == S_IDLE)
    `NTA_ASSERT_IMP(a_live_max, clk, rst_n, 1'b1, live_reg <= CW'(MAX_TRACKS))
    `NTA_ASSERT_NXT(a_one_item, clk, rst_n, accept, !det.ready)
endmodule

// ===== verif/tb_nearest_track_association.sv =====
module tb_nearest_track_association;
    timeunit 1ns;
    timeprecision 1ps;
    import nta_pkg::*;

    localparam int TRACKS    = 64;
    localparam int STALL_MAX = 6000;
    localparam int SETTLE    = 90;

    typedef struct {
        logic [CMD_BITS-1:0]  cmd;
        logic [10:0]          x;
        logic [10:0]          y;
        logic [10:0]          w;
        logic [10:0]          h;
        logic [AREA_BITS-1:0] area;
        logic [LANE_BITS-1:0] lane;
    } det_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_index = REG_MIN_AREA;
    logic [AREA_BITS-1:0] cfg_data = '0;

    nta_det_if det_ch ();
    nta_res_if res_ch ();

    nearest_track_association dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .det       (det_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [10:0] track_x [TRACKS];
    logic [10:0] track_y [TRACKS];
    logic [10:0] track_w [TRACKS];
    logic [10:0] track_h [TRACKS];
    logic [3:0]  track_lane [TRACKS];
    logic [1:0]  track_col [TRACKS];
    bit          track_seen [TRACKS];
    int          live_tracks = 0;
    logic [15:0] lane_changes = '0;
    logic [AREA_BITS-1:0] area_floor = MIN_AREA_RST;
    logic [RAD_BITS-1:0]  radius = RADIUS_RST;

    result_t expected_results [$];
    int errors = 0;
    int n_sent = 0;
    int n_status [5] = '{default: 0};
    bit idle_on = 1'b1;
    bit stall_on = 1'b1;
    int burst_left = 0;
    int quiet_cycles = 0;

    function automatic int centre(logic [10:0] c, logic [10:0] s);
        return (2 * int'(c) + int'(s)) >> 1;
    endfunction

    function automatic longint sq(int a, int b);
        longint d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    function automatic result_t associate(det_t d);
        result_t r;
        int n;
        int best;
        bit found;
        longint bestd;
        longint sq_dist;
        int cx;
        int cy;
        r = '0;
        found = 1'b0;
        best = 0;
        bestd = 0;
        if (d.cmd == CMD_FRAME)
        begin
            n = 0;
            for (int i = 0; i < live_tracks; i++)
                if (track_seen[i])
                begin
                    track_x[n] = track_x[i];
                    track_y[n] = track_y[i];
                    track_w[n] = track_w[i];
                    track_h[n] = track_h[i];
                    track_lane[n] = track_lane[i];
                    track_col[n] = track_col[i];
                    n++;
                end
            live_tracks = n;
            foreach (track_seen[i]) track_seen[i] = 1'b0;
            r.status = ST_FRAME;
        end
        else if (d.area < area_floor)
            r.status = ST_SMALL;
        else
        begin
            cx = centre(d.x, d.w);
            cy = centre(d.y, d.h);
            for (int i = 0; i < live_tracks; i++)
            begin
                sq_dist = sq(centre(track_x[i], track_w[i]), cx)
                        + sq(centre(track_y[i], track_h[i]), cy);
                if (sq_dist <= longint'(radius) * radius && (!found || sq_dist < bestd))
                begin
                    found = 1'b1;
                    bestd = sq_dist;
                    best = i;
                end
            end
            if (found)
            begin
                if (track_lane[best] != d.lane)
                begin
                    track_lane[best] = d.lane;
                    track_col[best] = COL_RED;
                    lane_changes++;
                    r.lane_changed = 1'b1;
                end
                track_x[best] = d.x;
                track_y[best] = d.y;
                if (d.w < track_w[best]) track_w[best] = d.w;
                if (d.h < track_h[best]) track_h[best] = d.h;
                track_seen[best] = 1'b1;
                r.status = ST_MATCH;
                r.track_index = best[5:0];
                r.color = track_col[best];
                r.out_x = track_x[best];
                r.out_y = track_y[best];
                r.out_width = track_w[best];
                r.out_height = track_h[best];
            end
            else if (live_tracks >= TRACKS)
                r.status = ST_FULL;
            else
            begin
                n = live_tracks;
                track_x[n] = d.x;
                track_y[n] = d.y;
                track_w[n] = d.w;
                track_h[n] = d.h;
                track_lane[n] = d.lane;
                if (d.lane == 4'd1)
                    track_col[n] = COL_BLUE;
                else if (d.lane == 4'd2)
                    track_col[n] = COL_GREEN;
                else
                begin
                    track_col[n] = COL_RED;
                    lane_changes++;
                    r.lane_changed = 1'b1;
                end
                track_seen[n] = 1'b1;
                live_tracks = n + 1;
                r.status = ST_NEW;
                r.track_index = n[5:0];
                r.color = track_col[n];
                r.out_x = d.x;
                r.out_y = d.y;
                r.out_width = d.w;
                r.out_height = d.h;
            end
        end
        r.changes_total = lane_changes;
        r.tracks_live = live_tracks[6:0];
        return r;
    endfunction

    task automatic send_item(det_t d);
        det_ch.valid <= 1'b1;
        det_ch.cmd <= d.cmd;
        det_ch.box_x <= d.x;
        det_ch.box_y <= d.y;
        det_ch.box_width <= d.w;
        det_ch.box_height <= d.h;
        det_ch.area <= d.area;
        det_ch.lane <= d.lane;
        do @(posedge clk); while (!det_ch.ready);
        expected_results.insert(expected_results.size(), associate(d));
        n_sent++;
        if (idle_on)
        begin
            if (burst_left == 0)
            begin
                det_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                burst_left = $urandom_range(0, 10);
            end
            else
                burst_left--;
        end
    endtask

    task automatic drain();
        det_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [AREA_BITS-1:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MIN_AREA)
            area_floor = val;
        else
            radius = val[RAD_BITS-1:0];
    endtask

    function automatic det_t box(int x, int y, int w, int h, int area, int lane);
        det_t d;
        d.cmd = CMD_DET;
        d.x = 11'(x);
        d.y = 11'(y);
        d.w = 11'(w);
        d.h = 11'(h);
        d.area = AREA_BITS'(area);
        d.lane = LANE_BITS'(lane);
        return d;
    endfunction

    function automatic det_t frame_end();
        det_t d;
        d = box($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                $urandom_range(0, 2047), $urandom_range(0, 8388607), $urandom_range(0, 15));
        d.cmd = CMD_FRAME;
        return d;
    endfunction

    function automatic int clip(int v);
        return (v < 0) ? 0 : (v > 2047) ? 2047 : v;
    endfunction

    function automatic det_t random_det();
        det_t d;
        int t;
        int j;
        d = box($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                $urandom_range(0, 2047), $urandom_range(0, 8388607), $urandom_range(0, 15));
        if ($urandom_range(0, 9) < 8)
            d.area = AREA_BITS'(int'(area_floor) + int'($urandom_range(0, 5000)));
        if (d.area > 4194304) d.area = 23'd4194304;
        if (live_tracks > 0 && $urandom_range(0, 9) < 7)
        begin
            t = $urandom_range(0, live_tracks - 1);
            j = (radius > 30) ? 30 : int'(radius) + 2;
            d.w = 11'(int'(track_w[t]) + int'($urandom_range(0, 8)));
            d.h = 11'(int'(track_h[t]) + int'($urandom_range(0, 8)));
            if (d.w < track_w[t]) d.w = track_w[t];
            if (d.h < track_h[t]) d.h = track_h[t];
            d.x = 11'(clip(int'(track_x[t]) - (int'(d.w) - int'(track_w[t])) / 2
                           + int'($urandom_range(0, 2 * j)) - j));
            d.y = 11'(clip(int'(track_y[t]) - (int'(d.h) - int'(track_h[t])) / 2
                           + int'($urandom_range(0, 2 * j)) - j));
            if ($urandom_range(0, 9) < 8) d.lane = track_lane[t];
        end
        return d;
    endfunction

    task automatic check_field(string name, longint exp, longint act);
        if (exp != act)
        begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (!stall_on)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(0, 15) < 11) ||
                            ($urandom_range(0, 63) == 0 && res_ch.ready);
    end

    always @(posedge clk)
    begin
        result_t e;
        result_t a;
        if (res_ch.valid && res_ch.ready)
        begin
            a = res_ch.res;
            if (expected_results.size() == 0)
            begin
                $error("result with no item outstanding, status %0d", a.status);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("status", e.status, a.status);
                check_field("track_index", e.track_index, a.track_index);
                check_field("lane_changed", e.lane_changed, a.lane_changed);
                check_field("color", e.color, a.color);
                check_field("out_x", e.out_x, a.out_x);
                check_field("out_y", e.out_y, a.out_y);
                check_field("out_width", e.out_width, a.out_width);
                check_field("out_height", e.out_height, a.out_height);
                check_field("changes_total", e.changes_total, a.changes_total);
                check_field("tracks_live", e.tracks_live, a.tracks_live);
                if (e.status <= ST_FRAME) n_status[e.status]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((det_ch.valid && det_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (det_ch.valid == 1'b0 && expected_results.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(box(0, 0, 0, 0, 799, 1));
        send_item(box(0, 0, 0, 0, 800, 1));
        send_item(box(2047, 2047, 2047, 2047, 4194304, 2));
        send_item(box(4, 2, 10, 10, 900, 2));
        send_item(box(1, 1, 4, 4, 1000, 1));
        send_item(box(500, 500, 20, 20, 1000, 0));
        send_item(box(1000, 1000, 8, 8, 1000, 15));
        send_item(box(1003, 1003, 30, 30, 1000, 7));
        send_item(box(1040, 1000, 8, 8, 1000, 7));
        send_item(box(1020, 1000, 8, 8, 1000, 7));
        send_item(frame_end());
        send_item(box(1020, 1000, 8, 8, 1000, 7));
        send_item(frame_end());
        send_item(frame_end());
    endtask

    task automatic test_table_full();
        write_reg(REG_RADIUS, '0);
        write_reg(REG_MIN_AREA, '0);
        for (int i = 0; i < TRACKS; i++)
            send_item(box(i * 31, i * 7, 0, 0, 0, i % 16));
        send_item(box(2047, 2047, 0, 0, 0, 3));
        send_item(box(0, 0, 0, 0, 0, 1));
        send_item(box(2000, 5, 1, 1, 0, 2));
        send_item(frame_end());
        send_item(frame_end());
    endtask

    task automatic test_random(int count, logic [AREA_BITS-1:0] floor_v, int rad);
        int left;
        write_reg(REG_MIN_AREA, floor_v);
        write_reg(REG_RADIUS, AREA_BITS'(rad));
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 11) == 0 || live_tracks > 40)
                send_item(frame_end());
            else
                send_item(random_det());
            left--;
        end
        send_item(frame_end());
    endtask

    task automatic test_no_idle(int count);
        idle_on = 1'b0;
        stall_on = 1'b0;
        test_random(count, MIN_AREA_RST, 25);
        idle_on = 1'b1;
        stall_on = 1'b1;
    endtask

    initial
    begin
        det_ch.valid = 1'b0;
        det_ch.cmd = CMD_DET;
        det_ch.box_x = '0;
        det_ch.box_y = '0;
        det_ch.box_width = '0;
        det_ch.box_height = '0;
        det_ch.area = '0;
        det_ch.lane = '0;
        foreach (track_seen[i]) track_seen[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random(200, MIN_AREA_RST, RADIUS_RST);
        test_random(150, 23'd4194304, 2047);
        test_random(150, 23'd0, 2047);
        test_no_idle(120);
        test_random(150, 23'd3000, 60);
        drain();
        $display("items sent %0d: matched %0d, new %0d, too small %0d, full %0d, frames %0d",
                 n_sent, n_status[ST_MATCH], n_status[ST_NEW], n_status[ST_SMALL],
                 n_status[ST_FULL], n_status[ST_FRAME]);
        $display("lane changes counted %0d over radius and area settings incl. extremes",
                 lane_changes);
        if (errors == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
